// ===== rtl/sle_pkg.sv =====
// ============================================================================
// sle_pkg
// Shared constants for the sequential list engine: field widths,
// operation codes and status codes.
// ============================================================================
package sle_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam int OP_W     = 2;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 7;
    localparam int LENGTH_W = 8;

    // input word: op, position, value -> 42 bits, padded to 48
    localparam int S_TDATA_W = 48;
    // result word: status, found_index, list_length -> 17 bits, padded to 24
    localparam int M_TDATA_W = 24;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== rtl/sequential_list_engine.sv =====
// ============================================================================
// sequential_list_engine
// Contiguous list of signed words in one synchronous RAM with a length
// count; insert, delete and locate requests, one status word per request.
// ============================================================================
// Usage:
//   Requests arrive on the s_ channel (op, position, value). Every accepted
//   request yields exactly one result word on the m_ channel (status,
//   found_index, list_length). One request is in flight at a time:
//   s_tready is high only while the engine is idle.
//   A rejected request (full, bad position, unused op, locate on an empty
//   list) goes straight to the result. Insert shifts the entries from the
//   position on up by one slot, none when appending at the end; delete
//   shifts the entries above the position down by one, none for the last
//   entry; locate reads from index 0 and stops at the first match or at the
//   end. The engine returns to idle before the next word is taken. The
//   single RAM read port sets the pace: the shift and the search step
//   through the stored entries one word per cycle, each shift read
//   pipelined against the write of the word read in the cycle before.
//   Reset (aresetn low, synchronous) empties the list and clears the
//   handshake state; RAM contents are not cleared, only entries below the
//   length are ever read.
//   When the receiver stalls, the result holds in the output register; the
//   engine accepts and works on the next request meanwhile and waits only
//   to hand over its own result.
// ============================================================================
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] op, [9:2] position, [41:10] value, [47:42] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [8:2] found_index, [16:9] list_length, [23:17] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // entry index
    localparam int CW = $clog2(DEPTH + 1);                 // length count
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;   // compare width

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SHIFT  = 4'b0010,
        S_LOCATE = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // input fields
    logic [OP_W-1:0]    s_op;
    logic [POS_W-1:0]   s_position;
    logic [VALUE_W-1:0] s_value;

    assign s_op       = s_tdata[OP_W-1:0];
    assign s_position = s_tdata[OP_W+POS_W-1:OP_W];
    assign s_value    = s_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W];

    // control / work registers
    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [AW-1:0]      slot_reg, slot_next;     // insert target index
    logic [AW-1:0]      cur_reg, cur_next;       // next index to read
    logic [AW-1:0]      stop_reg, stop_next;     // last index to read
    logic               issue_reg, issue_next;   // reads left to issue
    logic               pend_valid_reg, pend_valid_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FOUND_W-1:0] res_found_reg, res_found_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM
    logic [VALUE_W-1:0] mem [DEPTH];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] rd_data_reg;

    // widened operands for bounds checks
    logic [XW-1:0] pos_x, cnt_x, dep_x;

    assign pos_x = XW'(s_position);
    assign cnt_x = XW'(count_reg);
    assign dep_x = XW'(DEPTH);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        stop_next       = stop_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = cur_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_op;
                    value_next      = s_value;
                    res_found_next  = '0;
                    res_status_next = ST_OK;
                    issue_next      = 1'b0;
                    state_next      = S_FINISH;
                    case (s_op)
                        OP_INSERT: begin
                            // full test comes before the position test
                            if (cnt_x >= dep_x) begin
                                res_status_next = ST_FULL;
                            end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                                res_status_next = ST_BADPOS;
                            end else begin
                                slot_next  = AW'(pos_x - XW'(1));
                                issue_next = (pos_x <= cnt_x);
                                cur_next   = AW'(cnt_x - XW'(1));
                                stop_next  = AW'(pos_x - XW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                res_status_next = ST_BADPOS;
                            end else begin
                                issue_next = (pos_x < cnt_x);
                                cur_next   = AW'(pos_x);
                                stop_next  = AW'(cnt_x - XW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        OP_LOCATE: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_NOTFOUND;
                            end else begin
                                issue_next = 1'b1;
                                cur_next   = '0;
                                stop_next  = AW'(cnt_x - XW'(1));
                                state_next = S_LOCATE;
                            end
                        end
                        default: begin
                            res_status_next = ST_BADPOS;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // read one word per cycle, write it one slot over in the next cycle
                if (issue_reg) begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    if (op_reg == OP_INSERT) begin
                        pend_addr_next = cur_reg + AW'(1);
                        cur_next       = cur_reg - AW'(1);
                    end else begin
                        pend_addr_next = cur_reg - AW'(1);
                        cur_next       = cur_reg + AW'(1);
                    end
                    if (cur_reg == stop_reg) begin
                        issue_next = 1'b0;
                    end
                end
                if (pend_valid_reg) begin
                    mem_we = 1'b1;
                end
                if (!issue_reg && !pend_valid_reg) begin
                    if (op_reg == OP_INSERT) begin
                        mem_we     = 1'b1;
                        mem_waddr  = slot_reg;
                        mem_wdata  = value_reg;
                        count_next = count_reg + CW'(1);
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                end
            end

            S_LOCATE: begin
                if (issue_reg) begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = cur_reg;
                    cur_next        = cur_reg + AW'(1);
                    if (cur_reg == stop_reg) begin
                        issue_next = 1'b0;
                    end
                end
                if (pend_valid_reg && rd_data_reg == value_reg) begin
                    // first match wins; drop the read already in flight
                    res_status_next = ST_OK;
                    res_found_next  = FOUND_W'(pend_addr_reg);
                    issue_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_FINISH;
                end else if (!issue_reg && !pend_valid_reg) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({LENGTH_W'(count_reg),
                                                res_found_reg,
                                                res_status_reg});
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        slot_reg       <= slot_next;
        cur_reg        <= cur_next;
        stop_reg       <= stop_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // list RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // length never exceeds capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(count_reg) <= dep_x)
        else $error("list length above capacity");

    // shift pipeline never reads the entry it writes in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("RAM read and write hit the same entry");

    // a finished request has no traffic left in the RAM pipeline
    a_finish_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH) |-> (!issue_reg && !pend_valid_reg))
        else $error("result pending while RAM accesses remain");

    // length moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg == $past(count_reg)
                            || count_reg == $past(count_reg) + CW'(1)
                            || count_reg == $past(count_reg) - CW'(1)))
        else $error("list length jumped");
`endif

endmodule
